// ===== hdl/tosu_pkg.sv =====
// Shared types, constants and saturation helpers for the true online SARSA update block.
`timescale 1ns / 1ps
package tosu_pkg;

  localparam int unsigned STATE_W   = 6;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned NUM_ACT   = 4;
  localparam int unsigned IDX_W     = STATE_W + ACT_W;
  localparam int unsigned TBL_DEPTH = 1 << IDX_W;
  localparam int unsigned QUEUE_DEP = 32;
  localparam int unsigned QPTR_W    = 5;
  localparam int unsigned QCNT_W    = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned COEF_W    = 17;
  localparam int unsigned PROD_W    = 49;
  localparam int unsigned SUM_W     = 52;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_W      = 56;
  localparam int unsigned OUT_W     = NUM_ACT * VAL_W;
  localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;
  localparam int unsigned ST_N      = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 3'd0,
    CFG_DECAY  = 3'd1,
    CFG_GAMMA  = 3'd2,
    CFG_THRESH = 3'd3,
    CFG_QLEN   = 3'd4,
    CFG_CLASSIC = 3'd5,
    CFG_LEARN  = 3'd6,
    CFG_NORM   = 3'd7
  } cfg_idx_e;

  typedef enum logic [ST_N-1:0] {
    ST_IDLE  = 29'd1 << 0,
    ST_TOUCH = 29'd1 << 1,
    ST_QN    = 29'd1 << 2,
    ST_QSA   = 29'd1 << 3,
    ST_C1    = 29'd1 << 4,
    ST_C2    = 29'd1 << 5,
    ST_C3    = 29'd1 << 6,
    ST_C4    = 29'd1 << 7,
    ST_T1    = 29'd1 << 8,
    ST_T2    = 29'd1 << 9,
    ST_T3    = 29'd1 << 10,
    ST_T4    = 29'd1 << 11,
    ST_T5    = 29'd1 << 12,
    ST_T6    = 29'd1 << 13,
    ST_T7    = 29'd1 << 14,
    ST_T8    = 29'd1 << 15,
    ST_T9    = 29'd1 << 16,
    ST_T10   = 29'd1 << 17,
    ST_LA    = 29'd1 << 18,
    ST_LD    = 29'd1 << 19,
    ST_LT    = 29'd1 << 20,
    ST_LM    = 29'd1 << 21,
    ST_LV    = 29'd1 << 22,
    ST_EPI   = 29'd1 << 23,
    ST_OA    = 29'd1 << 24,
    ST_OD    = 29'd1 << 25,
    ST_ON    = 29'd1 << 26,
    ST_DONE  = 29'd1 << 27,
    ST_CLR   = 29'd1 << 28
  } state_e;

  function automatic logic signed [SUM_W-1:0] ext_val(input logic signed [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
    return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = ext_val(32'sh7FFF_FFFF);
    lo = ext_val(32'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] coef_clip(input logic [COEF_W-1:0] v);
    return (v > COEF_ONE) ? COEF_ONE : v;
  endfunction

endpackage

// ===== hdl/true_online_sarsa_update.sv =====
// Top level of the true online SARSA(lambda) update block with tabular Q values.
`timescale 1ns / 1ps
// Usage
//   s_axis: one item per transfer. tdata holds state, action, reward, next state,
//   next action and query state; tuser is do_update, tlast is episode end.
//   m_axis: one item per input item, the four Q16.16 values of the query state.
//   cfg: register index and data, taken in any cycle; write only while idle.
// Sequencing
//   One shared 32x32 multiplier with a registered product serves every multiplication.
//   Read only: the four Q values of the query state are read in turn, each scaled
//   when output scaling is on; the next item is taken once the sequencer is idle again.
//   Classic update: one value write. True online update: the pair's trace and value,
//   then the traces of each queued state: those above the threshold decay and update
//   their value, those at or below it are cleared; the updated pair is skipped.
//   Episode end on the update path: a clearing pass over the trace table follows.
//   s_axis_tready is high only while the sequencer is idle.
// Reset
//   A clearing pass zeroes both tables while s_axis_tready is low;
//   queue empty, registers at their defaults.
// Stall
//   The finished item waits in the output register; the next item is accepted
//   meanwhile and its result holds in the sequencer until the register frees.
module true_online_sarsa_update import tosu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // state[5:0], action[7:6], reward[39:8], nstate[45:40], naction[47:46],
  // query_state[53:48], zero[55:54]
  input  logic [IN_W-1:0]      s_axis_tdata,
  // do_update
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // q_action_0[31:0], q_action_1[63:32], q_action_2[95:64], q_action_3[127:96]
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  state_e st_q, st_d;

  logic [COEF_W-1:0] step_q, lam_q, gam_q, thr_q;
  logic [QCNT_W-1:0] qlen_q;
  logic classic_q, learn_q, norm_q;

  logic [STATE_W-1:0] s_q, qs_q;
  logic [IDX_W-1:0]   sa_q, nsa_q, idx_q, idx_c;
  logic signed [VAL_W-1:0] r_q;
  logic end_q;

  logic signed [VAL_W-1:0] qn_q, qsa_q, tsa_q, lg_q, delta_q, diff_q, ad_q, tmp_q, v_q;
  logic signed [VAL_W-1:0] prev_q, tmp_d;
  logic signed [PROD_W-1:0] t1_q;
  logic [QCNT_W-1:0] cnt_q, i_q;
  logic [ACT_W-1:0]  j_q, oj_q;
  logic adv;
  logic signed [VAL_W-1:0] res_q [NUM_ACT];
  logic [OUT_W-1:0] m_data_q;
  logic m_valid_q;
  logic [IDX_W-1:0] clr_q;
  logic clr_all_q;

  // shared multiplier
  logic signed [VAL_W-1:0] mul_a, mul_b;
  logic [VAL_W-1:0] ua, ub;
  logic [2*VAL_W-1:0] full;
  logic [PROD_W-2:0] pm;
  logic mneg;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  always_comb begin
    mneg = mul_a[VAL_W-1] ^ mul_b[VAL_W-1];
    ua = mul_a[VAL_W-1] ? VAL_W'(-mul_a) : VAL_W'(mul_a);
    ub = mul_b[VAL_W-1] ? VAL_W'(-mul_b) : VAL_W'(mul_b);
    full = 64'(ua) * 64'(ub) + 64'h8000;
    pm = full[2*VAL_W-1:16];
    prod_d = mneg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // tables
  logic [VAL_W-1:0] val_mem [TBL_DEPTH];
  logic [VAL_W-1:0] trc_mem [TBL_DEPTH];
  logic [IDX_W-1:0] rd_addr, val_wa, trc_wa;
  logic val_we, trc_we, trc_clr;
  logic signed [VAL_W-1:0] val_wd, trc_wd;
  logic [VAL_W-1:0] val_rd_q, trc_rd_q;
  logic signed [VAL_W-1:0] val_rd, trc_rd;

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (trc_we) begin
      trc_mem[trc_wa] <= trc_wd;
    end
    val_rd_q <= val_mem[rd_addr];
    trc_rd_q <= trc_mem[rd_addr];
  end

  assign val_rd = $signed(val_rd_q);
  assign trc_rd = $signed(trc_rd_q);

  // recency queue
  logic [STATE_W-1:0] queue_q [QUEUE_DEP];
  logic [STATE_W-1:0] queue_d [QUEUE_DEP];
  logic q_touch;
  logic [QCNT_W-1:0] cap, cnt_touch;
  logic [QPTR_W-1:0] first_m;
  logic hit, do_shift, do_app;

  always_comb begin
    cap = qlen_q;
    if (qlen_q == '0) begin
      cap = QCNT_W'(1);
    end else if (qlen_q > QCNT_W'(QUEUE_DEP)) begin
      cap = QCNT_W'(QUEUE_DEP);
    end
    hit = 1'b0;
    first_m = '0;
    for (int k = QUEUE_DEP - 1; k >= 0; k--) begin
      if ((QCNT_W'(k) < cnt_q) && (queue_q[k] == s_q)) begin
        hit = 1'b1;
        first_m = QPTR_W'(k);
      end
    end
    do_app = !hit && (cnt_q < cap);
    do_shift = !do_app;
    cnt_touch = do_app ? cnt_q + QCNT_W'(1) : cnt_q;
    for (int k = 0; k < QUEUE_DEP; k++) begin
      queue_d[k] = queue_q[k];
      if (do_shift && (QPTR_W'(k) >= first_m) && (QCNT_W'(k + 1) < cnt_q)) begin
        queue_d[k] = queue_q[(k + 1) % QUEUE_DEP];
      end
      if (do_shift && (QCNT_W'(k + 1) == cnt_q)) begin
        queue_d[k] = s_q;
      end
      if (do_app && (QCNT_W'(k) == cnt_q)) begin
        queue_d[k] = s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_touch) begin
      queue_q <= queue_d;
    end
  end

  // sequencer
  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;

  always_comb begin
    st_d = st_q;
    mul_a = '0;
    mul_b = '0;
    rd_addr = '0;
    val_we = 1'b0;
    val_wa = sa_q;
    val_wd = '0;
    trc_we = 1'b0;
    trc_wa = sa_q;
    trc_wd = '0;
    trc_clr = 1'b0;
    q_touch = 1'b0;
    adv = 1'b0;
    tmp_d = '0;
    idx_c = {queue_q[i_q[QPTR_W-1:0]], j_q};
    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          st_d = (s_axis_tuser && learn_q) ? ST_TOUCH : ST_OA;
        end
      end
      ST_TOUCH: begin
        q_touch = 1'b1;
        rd_addr = nsa_q;
        st_d = ST_QN;
      end
      ST_QN: begin
        rd_addr = sa_q;
        st_d = ST_QSA;
      end
      ST_QSA: begin
        st_d = classic_q ? ST_C1 : ST_T1;
      end
      ST_C1: begin
        mul_a = VAL_W'(gam_q);
        mul_b = qn_q;
        st_d = ST_C2;
      end
      ST_C2: begin
        tmp_d = sat32(ext_val(r_q) + ext_prod(prod_q) - ext_val(qsa_q));
        st_d = ST_C3;
      end
      ST_C3: begin
        mul_a = VAL_W'(step_q);
        mul_b = tmp_q;
        st_d = ST_C4;
      end
      ST_C4: begin
        val_we = 1'b1;
        val_wd = sat32(ext_val(qsa_q) + ext_prod(prod_q));
        st_d = ST_EPI;
      end
      ST_T1: begin
        mul_a = VAL_W'(lam_q);
        mul_b = VAL_W'(gam_q);
        st_d = ST_T2;
      end
      ST_T2: begin
        mul_a = VAL_W'(gam_q);
        mul_b = qn_q;
        st_d = ST_T3;
      end
      ST_T3: begin
        st_d = ST_T4;
      end
      ST_T4: begin
        mul_a = VAL_W'(step_q);
        mul_b = sat32(ext_val(delta_q) + ext_val(diff_q));
        st_d = ST_T5;
      end
      ST_T5: begin
        mul_a = lg_q;
        mul_b = VAL_W'(COEF_ONE - step_q);
        st_d = ST_T6;
      end
      ST_T6: begin
        mul_a = prod_q[VAL_W-1:0];
        mul_b = tsa_q;
        st_d = ST_T7;
      end
      ST_T7: begin
        tmp_d = sat32(ext_prod(prod_q) + ext_val(VAL_W'(COEF_ONE)));
        trc_we = 1'b1;
        trc_wd = tmp_d;
        st_d = ST_T8;
      end
      ST_T8: begin
        mul_a = ad_q;
        mul_b = tmp_q;
        st_d = ST_T9;
      end
      ST_T9: begin
        mul_a = VAL_W'(step_q);
        mul_b = diff_q;
        st_d = ST_T10;
      end
      ST_T10: begin
        val_we = 1'b1;
        val_wd = sat32(ext_val(qsa_q) + ext_prod(t1_q) - ext_prod(prod_q));
        st_d = ST_LA;
      end
      ST_LA: begin
        if (i_q >= cnt_q) begin
          st_d = ST_EPI;
        end else if (idx_c == sa_q) begin
          adv = 1'b1;
        end else begin
          rd_addr = idx_c;
          st_d = ST_LD;
        end
      end
      ST_LD: begin
        if (trc_rd > $signed({{(VAL_W-COEF_W){1'b0}}, thr_q})) begin
          mul_a = lg_q;
          mul_b = trc_rd;
          st_d = ST_LT;
        end else begin
          trc_we = 1'b1;
          trc_wa = idx_q;
          adv = 1'b1;
          st_d = ST_LA;
        end
      end
      ST_LT: begin
        tmp_d = sat32(ext_prod(prod_q));
        trc_we = 1'b1;
        trc_wa = idx_q;
        trc_wd = tmp_d;
        st_d = ST_LM;
      end
      ST_LM: begin
        mul_a = ad_q;
        mul_b = tmp_q;
        st_d = ST_LV;
      end
      ST_LV: begin
        val_we = 1'b1;
        val_wa = idx_q;
        val_wd = sat32(ext_val(v_q) + ext_prod(prod_q));
        adv = 1'b1;
        st_d = ST_LA;
      end
      ST_EPI: begin
        trc_clr = end_q;
        st_d = end_q ? ST_CLR : ST_OA;
      end
      ST_CLR: begin
        trc_we = 1'b1;
        trc_wa = clr_q;
        val_we = clr_all_q;
        val_wa = clr_q;
        if (clr_q == '1) begin
          st_d = clr_all_q ? ST_IDLE : ST_OA;
        end
      end
      ST_OA: begin
        rd_addr = {qs_q, oj_q};
        st_d = ST_OD;
      end
      ST_OD: begin
        if (norm_q) begin
          mul_a = VAL_W'(COEF_ONE - gam_q);
          mul_b = val_rd;
          st_d = ST_ON;
        end else begin
          st_d = (oj_q == ACT_W'(NUM_ACT - 1)) ? ST_DONE : ST_OA;
        end
      end
      ST_ON: begin
        st_d = (oj_q == ACT_W'(NUM_ACT - 1)) ? ST_DONE : ST_OA;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLR;
      step_q    <= 17'd65536;
      lam_q     <= 17'd58982;
      gam_q     <= 17'd58982;
      thr_q     <= 17'd655;
      qlen_q    <= 6'd21;
      classic_q <= 1'b0;
      learn_q   <= 1'b1;
      norm_q    <= 1'b0;
      cnt_q     <= '0;
      prev_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      oj_q      <= '0;
      m_valid_q <= 1'b0;
      clr_q     <= '0;
      clr_all_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_STEP:    step_q    <= coef_clip(cfg_data_i);
          CFG_DECAY:   lam_q     <= coef_clip(cfg_data_i);
          CFG_GAMMA:   gam_q     <= coef_clip(cfg_data_i);
          CFG_THRESH:  thr_q     <= coef_clip(cfg_data_i);
          CFG_QLEN:    qlen_q    <= cfg_data_i[QCNT_W-1:0];
          CFG_CLASSIC: classic_q <= cfg_data_i[0];
          CFG_LEARN:   learn_q   <= cfg_data_i[0];
          CFG_NORM:    norm_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (q_touch) begin
        cnt_q <= cnt_touch;
      end
      if (st_q == ST_T10) begin
        prev_q <= qn_q;
        i_q    <= '0;
        j_q    <= '0;
      end
      if (adv) begin
        j_q <= j_q + ACT_W'(1);
        if (j_q == ACT_W'(NUM_ACT - 1)) begin
          i_q <= i_q + QCNT_W'(1);
        end
      end
      if (trc_clr) begin
        cnt_q  <= '0;
        prev_q <= '0;
      end
      if (st_q == ST_CLR) begin
        clr_q <= clr_q + IDX_W'(1);
        if (clr_q == '1) begin
          clr_all_q <= 1'b0;
        end
      end
      if (accept) begin
        oj_q <= '0;
      end
      if ((st_q == ST_ON) || ((st_q == ST_OD) && !norm_q)) begin
        oj_q <= oj_q + ACT_W'(1);
      end
      if ((st_q == ST_DONE) && (st_d == ST_IDLE)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q   <= s_axis_tdata[5:0];
      r_q   <= $signed(s_axis_tdata[39:8]);
      nsa_q <= {s_axis_tdata[45:40], s_axis_tdata[47:46]};
      sa_q  <= {s_axis_tdata[5:0], s_axis_tdata[7:6]};
      qs_q  <= s_axis_tdata[53:48];
      end_q <= s_axis_tlast;
    end
    case (st_q)
      ST_QN:  qn_q <= val_rd;
      ST_QSA: begin
        qsa_q <= val_rd;
        tsa_q <= trc_rd;
      end
      ST_C2:  tmp_q <= tmp_d;
      ST_T2:  lg_q <= prod_q[VAL_W-1:0];
      ST_T3: begin
        delta_q <= sat32(ext_val(r_q) + ext_prod(prod_q) - ext_val(qsa_q));
        diff_q  <= sat32(ext_val(qsa_q) - ext_val(prev_q));
      end
      ST_T5:  ad_q <= sat32(ext_prod(prod_q));
      ST_T7:  tmp_q <= tmp_d;
      ST_T9:  t1_q <= prod_q;
      ST_LA:  idx_q <= idx_c;
      ST_LD:  v_q <= val_rd;
      ST_LT:  tmp_q <= tmp_d;
      ST_OD: begin
        if (!norm_q) begin
          res_q[oj_q] <= val_rd;
        end
      end
      ST_ON:  res_q[oj_q] <= sat32(ext_prod(prod_q));
      default: ;
    endcase
    if ((st_q == ST_DONE) && (st_d == ST_IDLE)) begin
      m_data_q <= {res_q[3], res_q[2], res_q[1], res_q[0]};
    end
  end

endmodule

// ===== hdl/tosu_checker.sv =====
// Port-level checker for the true online SARSA update block, with its bind.
`timescale 1ns / 1ps
module tosu_checker import tosu_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready after accept");

  // a result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result while busy");

  // no result in the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result too early");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled item changed");

endmodule

bind true_online_sarsa_update tosu_checker u_tosu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/true_online_sarsa_update_tb.sv =====
// Self-checking testbench for the true online SARSA(lambda) update block.
`timescale 1ns / 1ps
module true_online_sarsa_update_tb;
  import tosu_pkg::*;

  typedef struct packed {
    logic             upd;
    logic [5:0]       st;
    logic [1:0]       act;
    logic [31:0]      rew;
    logic [5:0]       nst;
    logic [1:0]       nact;
    logic             epi;
    logic [5:0]       qst;
  } trans_t;

  typedef struct {
    logic [31:0] q[4];
  } qrow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_STEP;
  logic [COEF_W-1:0] cfg_data_i = '0;

  true_online_sarsa_update uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  longint q_tab[256];
  longint e_tab[256];
  int unsigned recent[32];
  int unsigned n_recent;
  longint prev_q;
  longint alpha, lambda_c, gamma_c, thresh;
  int unsigned qlen;
  bit classic, learn, norm;

  trans_t pend_mem[2048];
  int pend_wr = 0;
  int pend_rd = 0;
  qrow_t due_mem[2048];
  int due_wr = 0;
  int due_rd = 0;
  bit in_taken = 1'b0;
  int send_idle, recv_idle;
  bit hold_send;
  int errors = 0;
  longint cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rmul(longint a, longint b, int sh);
    bit neg;
    longint unsigned ua, ub, p;
    a = clip32(a);
    b = clip32(b);
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic void touch_recent(int unsigned s);
    int unsigned cap;
    cap = qlen < 1 ? 1 : (qlen > 32 ? 32 : qlen);
    for (int i = 0; i < n_recent; i++)
      if (recent[i] == s) begin
        for (int k = i; k + 1 < n_recent; k++) recent[k] = recent[k + 1];
        recent[n_recent - 1] = s;
        return;
      end
    if (n_recent < cap) begin
      recent[n_recent] = s;
      n_recent++;
      return;
    end
    for (int k = 0; k + 1 < n_recent; k++) recent[k] = recent[k + 1];
    recent[n_recent - 1] = s;
  endfunction

  task automatic apply_config(cfg_idx_e idx, logic [16:0] v);
    longint c;
    c = v > 17'd65536 ? 65536 : v;
    case (idx)
      CFG_STEP: alpha = c;
      CFG_DECAY: lambda_c = c;
      CFG_GAMMA: gamma_c = c;
      CFG_THRESH: thresh = c;
      CFG_QLEN: qlen = v[5:0];
      CFG_CLASSIC: classic = v[0];
      CFG_LEARN: learn = v[0];
      CFG_NORM: norm = v[0];
      default: ;
    endcase
  endtask

  function automatic qrow_t predict_row(trans_t t);
    qrow_t r;
    int unsigned sa, nsa, s, a;
    longint rew, lg, qn, qsa, dl, df, ad, dfirst, v;
    s = t.st;
    a = t.act;
    sa = s * 4 + a;
    nsa = t.nst * 4 + t.nact;
    rew = longint'($signed(t.rew));
    if (t.upd && learn) begin
      touch_recent(s);
      if (classic) begin
        qsa = q_tab[sa];
        dl = clip32(rew + rmul(gamma_c, q_tab[nsa], 16) - qsa);
        q_tab[sa] = clip32(qsa + rmul(alpha, dl, 16));
      end else begin
        lg = rmul(lambda_c, gamma_c, 16);
        qn = q_tab[nsa];
        qsa = q_tab[sa];
        dl = clip32(rew + rmul(gamma_c, qn, 16) - qsa);
        df = clip32(qsa - prev_q);
        ad = clip32(rmul(alpha, clip32(dl + df), 16));
        dfirst = rmul(lg, 65536 - alpha, 16);
        prev_q = qn;
        e_tab[sa] = clip32(rmul(dfirst, e_tab[sa], 16) + 65536);
        q_tab[sa] = clip32(qsa + rmul(ad, e_tab[sa], 16) - rmul(alpha, df, 16));
        for (int i = 0; i < n_recent; i++)
          for (int j = 0; j < 4; j++) begin
            int unsigned ix;
            ix = recent[i] * 4 + j;
            if (!(recent[i] == s && j == a)) begin
              if (e_tab[ix] > thresh) begin
                e_tab[ix] = clip32(rmul(lg, e_tab[ix], 16));
                q_tab[ix] = clip32(q_tab[ix] + rmul(ad, e_tab[ix], 16));
              end else e_tab[ix] = 0;
            end
          end
      end
      if (t.epi) begin
        n_recent = 0;
        foreach (e_tab[i]) e_tab[i] = 0;
        prev_q = 0;
      end
    end
    for (int j = 0; j < 4; j++) begin
      v = q_tab[t.qst * 4 + j];
      if (norm) v = clip32(rmul(65536 - gamma_c, v, 16));
      r.q[j] = v[31:0];
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pend_rd < pend_wr && !hold_send && $urandom_range(99) >= send_idle) begin
          trans_t t;
          t = pend_mem[pend_rd];
          pend_rd++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, t.qst, t.nact, t.nst, t.rew, t.act, t.st};
          s_axis_tuser <= t.upd;
          s_axis_tlast <= t.epi;
          due_mem[due_wr] = predict_row(t);
          due_wr++;
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_rd == due_wr) begin
        $display("%0t: unexpected row %h", $time, m_axis_tdata);
        errors++;
      end else begin
        qrow_t w;
        w = due_mem[due_rd];
        due_rd++;
        for (int j = 0; j < 4; j++)
          if (m_axis_tdata[j*32 +: 32] !== w.q[j]) begin
            $display("%0t: q_action_%0d expected %h actual %h", $time, j, w.q[j],
                     m_axis_tdata[j*32 +: 32]);
            errors++;
          end
      end
    end
    if (cycles > 10000000) begin
      $display("true_online_sarsa_update_tb failed");
      $finish;
    end
  end

  task automatic add_item(trans_t t);
    pend_mem[pend_wr] = t;
    pend_wr++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [16:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_config(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pend_rd < pend_wr || due_rd < due_wr || s_axis_tvalid) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  function automatic trans_t rand_trans(int unsigned nstates);
    trans_t t;
    t.upd = $urandom_range(99) < 85;
    t.st = 6'($urandom_range(nstates - 1));
    t.act = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: t.rew = $urandom;
      1: t.rew = $urandom_range(131072) - 65536;
      2: t.rew = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: t.rew = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    t.nst = 6'($urandom_range(nstates - 1));
    t.nact = 2'($urandom_range(3));
    t.epi = $urandom_range(99) < 8;
    t.qst = $urandom_range(1) ? t.st : 6'($urandom);
    return t;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      add_item(rand_trans($urandom_range(1) ? 64 : 8));
    drain();
  endtask

  initial begin
    trans_t t;
    foreach (q_tab[i]) begin
      q_tab[i] = 0;
      e_tab[i] = 0;
    end
    n_recent = 0;
    prev_q = 0;
    alpha = 65536; lambda_c = 58982; gamma_c = 58982; thresh = 655;
    qlen = 21; classic = 0; learn = 1; norm = 0;
    send_idle = 6;
    recv_idle = 45;
    hold_send = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, episode end, read only, saturation
    t = '{1'b1, 6'd0, 2'd0, 32'h7FFF_FFFF, 6'd63, 2'd3, 1'b0, 6'd0};
    add_item(t);
    t = '{1'b1, 6'd63, 2'd3, 32'h8000_0000, 6'd0, 2'd0, 1'b0, 6'd63};
    add_item(t);
    t = '{1'b1, 6'd0, 2'd0, 32'h7FFF_FFFF, 6'd0, 2'd0, 1'b0, 6'd0};
    add_item(t);
    t = '{1'b1, 6'd0, 2'd0, 32'h7FFF_FFFF, 6'd0, 2'd0, 1'b0, 6'd0};
    add_item(t);
    t = '{1'b1, 6'd21, 2'd2, 32'h0001_0000, 6'd42, 2'd1, 1'b1, 6'd21};
    add_item(t);
    t = '{1'b0, 6'd63, 2'd3, 32'hFFFF_FFFF, 6'd63, 2'd3, 1'b1, 6'd0};
    add_item(t);
    t = '{1'b1, 6'd42, 2'd1, 32'h0000_0000, 6'd21, 2'd2, 1'b1, 6'd42};
    add_item(t);
    drain();

    // queue twenty items with the sender held, then release it and drain
    hold_send = 1;
    for (int i = 0; i < 20; i++) add_item(rand_trans(4));
    repeat (50) @(posedge clk_i);
    hold_send = 0;
    drain();

    write_reg(CFG_QLEN, 17'd2);
    random_phase(60);
    write_reg(CFG_STEP, 17'h1FFFF);
    write_reg(CFG_DECAY, 17'd0);
    write_reg(CFG_GAMMA, 17'd65536);
    write_reg(CFG_THRESH, 17'd0);
    write_reg(CFG_QLEN, 17'd63);
    random_phase(150);
    write_reg(CFG_STEP, 17'd0);
    write_reg(CFG_DECAY, 17'h1FFFF);
    write_reg(CFG_GAMMA, 17'd0);
    write_reg(CFG_THRESH, 17'h1FFFF);
    write_reg(CFG_QLEN, 17'd0);
    write_reg(CFG_NORM, 17'd1);
    random_phase(100);

    send_idle = 45;
    recv_idle = 6;
    write_reg(CFG_CLASSIC, 17'd1);
    write_reg(CFG_STEP, 17'd32768);
    write_reg(CFG_GAMMA, 17'd58982);
    random_phase(150);
    write_reg(CFG_CLASSIC, 17'd0);
    write_reg(CFG_LEARN, 17'd0);
    random_phase(80);
    write_reg(CFG_LEARN, 17'd1);
    write_reg(CFG_NORM, 17'd0);
    write_reg(CFG_DECAY, 17'd58982);
    write_reg(CFG_THRESH, 17'd655);
    write_reg(CFG_QLEN, 17'd32);
    random_phase(200);

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_QLEN, 17'd5);
    random_phase(250);
    write_reg(CFG_STEP, 17'd65536);
    write_reg(CFG_QLEN, 17'd21);
    random_phase(300);

    if (errors == 0) begin
      $display("true_online_sarsa_update_tb passed");
    end else begin
      $display("true_online_sarsa_update_tb failed");
    end
    $finish;
  end
endmodule
